// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// each macro samples on clk; SRPG_ASSERT is disabled by the synchronous reset rst of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define SRPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define SRPG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/srpg_pkg.sv
// package for the stepper ramp pulse generator: constants, register indexes, item types
// no dependencies
`timescale 1ns / 1ps

package srpg_pkg;

  // default parameter values
  localparam int PULSE_WIDTH_US_DEF  = 50;
  localparam int SPEED_FRAC_BITS_DEF = 8;
  localparam int POSITION_WIDTH_DEF  = 32;

  // configuration port
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_START    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_RUN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DECEL_DEFAULT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MIN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MID      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_MAX      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_HOME     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_APPROACH = 3'd7;

  // register reset values
  localparam logic [23:0] ACCEL_START_RST    = 24'd1000;
  localparam logic [23:0] ACCEL_RUN_RST      = 24'd64000;
  localparam logic [23:0] DECEL_DEFAULT_RST  = 24'd64000;
  localparam logic [15:0] SPEED_MIN_RST      = 16'd80;
  localparam logic [15:0] SPEED_MID_RST      = 16'd400;
  localparam logic [15:0] SPEED_MAX_RST      = 16'd8000;
  localparam logic [15:0] SPEED_HOME_RST     = 16'd2500;
  localparam logic [15:0] SPEED_APPROACH_RST = 16'd80;

  // operations
  localparam logic OP_TICK      = 1'b0;
  localparam logic OP_SET_MODE  = 1'b1;

  // motion modes
  localparam logic [2:0] MODE_STOP     = 3'd0;
  localparam logic [2:0] MODE_START    = 3'd1;
  localparam logic [2:0] MODE_RUN      = 3'd2;
  localparam logic [2:0] MODE_DECEL    = 3'd3;
  localparam logic [2:0] MODE_HOME     = 3'd4;
  localparam logic [2:0] MODE_APPROACH = 3'd5;
  localparam logic [2:0] MODE_HALT     = 3'd6;
  localparam logic [2:0] MODE_KEEP     = 3'd7;

  // time constants
  localparam int          US_PER_S     = 1000000;
  localparam int          LASER_MUL    = 200;
  localparam int          LASER_DIV    = 3;
  localparam logic [19:0] CNT20_MAX    = 20'hFFFFF;
  localparam logic [7:0]  CNT8_MAX     = 8'hFF;

  typedef struct packed {
    logic       operation;
    logic [2:0] mode_value;
    logic       dir_pin_value;
    logic       clear_position;
    logic       laser_low;
    logic       laser_edge;
    logic       limits_clear;
    logic       running;
  } in_item_t;

  typedef struct packed {
    logic               pulse_level;
    logic               dir_level;
    logic [2:0]         mode_now;
    logic [15:0]        speed_now;
    logic signed [31:0] position_actual;
    logic signed [31:0] position_measured;
  } out_item_t;

endpackage

// File: hw/rtl/srpg_chan_if.sv
// valid/ready channel carrying one item type
// no dependencies
`timescale 1ns / 1ps

interface srpg_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/stepper_ramp_pulse_generator.sv
// channel      dir  payload     accepted when
// item_in      in   in_item_t   valid & ready
// item_out     out  out_item_t  valid & ready
// cfg          in   index/data  cfg_we high
//
// mode writes and ticks with no step event go from S_IDLE to S_DONE; a laser edge adds one
// bit-serial division of QW quotient bits, QW = 24 + 2*SPEED_FRAC_BITS (40 by default),
// a step event adds S_STEP, S_APPLY and up to two more divisions (ramp delta, interval),
// and all divisions run on the one shared divider.
// reset is synchronous and needs no clearing pass; item_in is taken only while
// no item is in work, and a result waits in the output register until taken.
// depends on srpg_pkg, srpg_chan_if, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stepper_ramp_pulse_generator
  import srpg_pkg::*;
#(
  parameter int PULSE_WIDTH_US  = PULSE_WIDTH_US_DEF,
  parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
  parameter int POSITION_WIDTH  = POSITION_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  srpg_chan_if.sink              item_in,
  srpg_chan_if.source            item_out,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int F       = SPEED_FRAC_BITS;
  localparam int SPEED_W = 16 + F;
  localparam int QW      = 24 + 2 * F;
  localparam int CNT_W   = $clog2(QW);
  localparam int EXT_W   = (POSITION_WIDTH > 32) ? POSITION_WIDTH : 32;
  localparam logic [SPEED_W-1:0] MAXQ = {SPEED_W{1'b1}};
  localparam logic [QW-1:0] IV_NUM  = QW'(US_PER_S) << F;
  localparam logic [SPEED_W-1:0] LASER_DEN = SPEED_W'(LASER_DIV) << F;
  localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
  localparam logic signed [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LDIV  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_RDIV  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_IDIV  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration registers
  logic [23:0] accel_start, accel_run, decel_default;
  logic [15:0] speed_min, speed_mid, speed_max, speed_home, speed_approach;

  // channel state
  logic [2:0]                       st;
  logic [SPEED_W-1:0]               speed;
  logic [2:0]                       mode;
  logic                             count_sign;
  logic                             dir_pin;
  logic signed [POSITION_WIDTH-1:0] actual_count, measured_count;
  logic [19:0]                      step_interval, since_step;
  logic [7:0]                       since_pulse_high;
  logic                             pulse_pending_low;
  logic                             pulse_pin;
  logic [23:0]                      decel_rate;
  logic                             step_hit, lat_laser_low, lat_limits_clear;
  logic                             out_valid;

  // serial divider
  logic                 div_busy;
  logic [CNT_W-1:0]     div_cnt;
  logic [QW-1:0]        div_num;
  logic [SPEED_W-1:0]   div_den, div_rem;
  logic [SPEED_W:0]     div_trial;
  logic                 div_bit;
  logic                 div_go;
  logic [QW-1:0]        div_num_in;
  logic [SPEED_W-1:0]   div_den_in;

  logic                 accept;
  logic                 laser_do;
  logic [19:0]          ss_inc;
  logic [7:0]           sph_inc;
  logic                 hit_now;
  logic [SPEED_W-1:0]   speed_nz;
  logic                 ramp_mode;
  logic [23:0]          ramp_rate;
  logic                 out_load;

  // step apply results
  logic [SPEED_W-1:0]   minq, midq, maxq, homeq, apprq;
  logic [QW:0]          sum_up;
  logic [SPEED_W-1:0]   up_val, down_val, s1, fin_speed;
  logic [2:0]           m1, fin_mode;
  logic                 cs1, dir1, go_iv;

  logic signed [EXT_W-1:0] act_ext, meas_ext;

  assign accept   = item_in.valid && item_in.ready;
  assign item_in.ready = (st == S_IDLE);
  assign laser_do = item_in.data.laser_edge && item_in.data.running;
  assign ss_inc   = (since_step < CNT20_MAX) ? since_step + 20'd1 : since_step;
  assign sph_inc  = (since_pulse_high < CNT8_MAX) ? since_pulse_high + 8'd1 : since_pulse_high;
  assign hit_now  = (ss_inc >= step_interval);
  assign speed_nz = (speed == '0) ? SPEED_W'(1) : speed;
  assign ramp_mode = (mode >= MODE_START) && (mode <= MODE_HALT);
  assign out_load = (st == S_DONE) && (!out_valid || item_out.ready);

  // ramp rate by mode
  always_comb begin
    case (mode)
      MODE_RUN:               ramp_rate = accel_run;
      MODE_DECEL, MODE_HALT:  ramp_rate = decel_rate;
      default:                ramp_rate = accel_start;
    endcase
  end

  // speed update of a step event, from the divider quotient
  assign minq  = {speed_min, F'(0)};
  assign midq  = {speed_mid, F'(0)};
  assign maxq  = {speed_max, F'(0)};
  assign homeq = {speed_home, F'(0)};
  assign apprq = {speed_approach, F'(0)};
  assign sum_up   = {1'b0, QW'(speed)} + {1'b0, div_num};
  assign up_val   = (sum_up > (QW + 1)'(MAXQ)) ? MAXQ : sum_up[SPEED_W-1:0];
  assign down_val = (div_num > QW'(speed)) ? '0 : speed - div_num[SPEED_W-1:0];

  always_comb begin
    s1   = speed;
    m1   = mode;
    cs1  = count_sign;
    dir1 = dir_pin;
    case (mode)
      MODE_START: begin
        s1 = up_val;
        if (up_val > midq) m1 = MODE_RUN;
      end
      MODE_RUN: s1 = up_val;
      MODE_DECEL: begin
        s1 = down_val;
        if (down_val < minq) begin
          s1   = minq;
          m1   = MODE_START;
          cs1  = lat_laser_low;
          dir1 = !lat_laser_low;
        end
      end
      MODE_HOME:     s1 = (up_val > homeq) ? homeq : up_val;
      MODE_APPROACH: s1 = (up_val > apprq) ? apprq : up_val;
      MODE_HALT: begin
        s1 = down_val;
        if (down_val < minq) begin
          s1 = minq;
          m1 = MODE_STOP;
        end
      end
      default: ;
    endcase
    if (s1 < minq) m1 = MODE_STOP;
    fin_speed = (s1 > maxq) ? maxq : s1;
    fin_mode  = m1;
    go_iv     = 1'b0;
    if (m1 != MODE_STOP) begin
      if (lat_limits_clear) go_iv = 1'b1;
      else fin_mode = MODE_DECEL;
    end else begin
      fin_speed = minq;
    end
  end

  // divider start requests
  always_comb begin
    div_go     = 1'b0;
    div_num_in = IV_NUM;
    div_den_in = (fin_speed == '0) ? SPEED_W'(1) : fin_speed;
    unique case (st)
      S_IDLE: begin
        div_go     = accept && (item_in.data.operation == OP_TICK) && laser_do;
        div_num_in = QW'(speed) * QW'(LASER_MUL);
        div_den_in = LASER_DEN;
      end
      S_STEP: begin
        div_go     = ramp_mode;
        div_num_in = QW'(ramp_rate) << (2 * F);
        div_den_in = speed_nz;
      end
      S_APPLY: div_go = go_iv;
      default: ;
    endcase
  end

  // one quotient bit per cycle
  assign div_trial = {div_rem, div_num[QW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (div_go) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      div_num  <= div_num_in;
      div_den  <= div_den_in;
      div_rem  <= '0;
    end else if (div_busy) begin
      div_rem <= div_bit ? SPEED_W'(div_trial - {1'b0, div_den}) : div_trial[SPEED_W-1:0];
      div_num <= {div_num[QW-2:0], div_bit};
      div_cnt <= div_cnt + CNT_W'(1);
      if (div_cnt == CNT_W'(QW - 1)) div_busy <= 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_start    <= ACCEL_START_RST;
      accel_run      <= ACCEL_RUN_RST;
      decel_default  <= DECEL_DEFAULT_RST;
      speed_min      <= SPEED_MIN_RST;
      speed_mid      <= SPEED_MID_RST;
      speed_max      <= SPEED_MAX_RST;
      speed_home     <= SPEED_HOME_RST;
      speed_approach <= SPEED_APPROACH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_START:    accel_start    <= cfg_data;
        REG_ACCEL_RUN:      accel_run      <= cfg_data;
        REG_DECEL_DEFAULT:  decel_default  <= cfg_data;
        REG_SPEED_MIN:      speed_min      <= cfg_data[15:0];
        REG_SPEED_MID:      speed_mid      <= cfg_data[15:0];
        REG_SPEED_MAX:      speed_max      <= cfg_data[15:0];
        REG_SPEED_HOME:     speed_home     <= cfg_data[15:0];
        REG_SPEED_APPROACH: speed_approach <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (item_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      st                <= S_IDLE;
      speed             <= {SPEED_MIN_RST, F'(0)};
      mode              <= MODE_STOP;
      count_sign        <= 1'b0;
      dir_pin           <= 1'b0;
      actual_count      <= '0;
      measured_count    <= '0;
      step_interval     <= '0;
      since_step        <= '0;
      since_pulse_high  <= '0;
      pulse_pending_low <= 1'b0;
      pulse_pin         <= 1'b0;
      decel_rate        <= DECEL_DEFAULT_RST;
    end else begin
      if (cfg_we && cfg_index == REG_DECEL_DEFAULT) decel_rate <= cfg_data;
      unique case (st)
        S_IDLE: if (accept) begin
          if (item_in.data.operation == OP_SET_MODE) begin
            if (item_in.data.mode_value != MODE_KEEP) mode <= item_in.data.mode_value;
            dir_pin <= item_in.data.dir_pin_value;
            if (item_in.data.clear_position) begin
              actual_count   <= '0;
              measured_count <= '0;
            end
            st <= S_DONE;
          end else begin
            lat_laser_low    <= item_in.data.laser_low;
            lat_limits_clear <= item_in.data.limits_clear;
            step_hit         <= hit_now;
            if (laser_do) begin
              if (item_in.data.laser_low) measured_count <= actual_count;
              mode <= MODE_DECEL;
            end
            since_step       <= hit_now ? '0 : ss_inc;
            since_pulse_high <= sph_inc;
            if (!hit_now && pulse_pending_low && sph_inc >= 8'(PULSE_WIDTH_US)) begin
              pulse_pending_low <= 1'b0;
              pulse_pin         <= 1'b0;
            end
            st <= laser_do ? S_LDIV : (hit_now ? S_STEP : S_DONE);
          end
        end
        S_LDIV: if (!div_busy) begin
          decel_rate <= (div_num[QW-1:24] != '0) ? 24'hFFFFFF : div_num[23:0];
          st <= step_hit ? S_STEP : S_DONE;
        end
        S_STEP: st <= ramp_mode ? S_RDIV : S_APPLY;
        S_RDIV: if (!div_busy) st <= S_APPLY;
        S_APPLY: begin
          speed      <= fin_speed;
          mode       <= fin_mode;
          count_sign <= cs1;
          dir_pin    <= dir1;
          st <= go_iv ? S_IDIV : S_DONE;
        end
        S_IDIV: if (!div_busy) begin
          step_interval     <= (div_num[QW-1:20] != '0) ? CNT20_MAX : div_num[19:0];
          pulse_pin         <= 1'b1;
          since_pulse_high  <= '0;
          pulse_pending_low <= 1'b1;
          if (count_sign) begin
            if (actual_count != POS_MIN) actual_count <= actual_count - POS_ONE;
          end else begin
            if (actual_count != POS_MAX) actual_count <= actual_count + POS_ONE;
          end
          st <= S_DONE;
        end
        S_DONE: if (out_load) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // output register, loaded when the item completes
  assign act_ext  = EXT_W'(actual_count);
  assign meas_ext = EXT_W'(measured_count);

  always_ff @(posedge clk) begin
    if (out_load) begin
      item_out.data.pulse_level       <= pulse_pin;
      item_out.data.dir_level         <= dir_pin;
      item_out.data.mode_now          <= mode;
      item_out.data.speed_now         <= speed[SPEED_W-1:F];
      item_out.data.position_actual   <= act_ext[31:0];
      item_out.data.position_measured <= meas_ext[31:0];
    end
  end

  assign item_out.valid = out_valid;

  // checks
  `SRPG_ASSERT(a_idle_div_quiet, (st == S_IDLE) |-> !div_busy, "divider busy while idle")
  `SRPG_ASSERT(a_accept_leaves_idle, accept |=> (st != S_IDLE), "accepted item not in work")
  `SRPG_ASSERT_ALWAYS(a_pin_pending, pulse_pin |-> pulse_pending_low, "pulse high without end pending")
  `SRPG_ASSERT(a_div_owner, div_busy |-> (st == S_LDIV || st == S_RDIV || st == S_IDIV), "divider runs outside a divide state")

endmodule

// File: tb/stepper_ramp_pulse_generator_test.sv
// self-checking testbench for stepper_ramp_pulse_generator: directed and random items
// through the valid/ready channels, results checked against an in-bench speed/position model
// depends on srpg_pkg, srpg_chan_if and the rtl top level
`timescale 1ns / 1ps

module stepper_ramp_pulse_generator_test;
  import srpg_pkg::*;

  localparam logic [23:0] SPEED_Q_MAX = 24'hFFFFFF;
  localparam int          PULSE_US    = PULSE_WIDTH_US_DEF;
  localparam int          FRAC        = SPEED_FRAC_BITS_DEF;
  localparam int          WATCHDOG    = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  srpg_chan_if #(.item_t(in_item_t))  item_in ();
  srpg_chan_if #(.item_t(out_item_t)) item_out ();

  stepper_ramp_pulse_generator uut (
    .clk(clk), .rst(rst), .item_in(item_in.sink), .item_out(item_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model registers
  logic [23:0] m_accel_start, m_accel_run, m_decel_default;
  logic [15:0] m_speed_min, m_speed_mid, m_speed_max, m_speed_home, m_speed_approach;

  // model state
  logic [23:0]        m_speed;
  logic [2:0]         m_mode;
  logic               m_count_neg;
  logic               m_dir;
  logic signed [31:0] m_pos_actual, m_pos_measured;
  logic [19:0]        m_interval, m_since_step;
  logic [7:0]         m_since_high;
  logic               m_pulse_pending, m_pulse;

  in_item_t  pending_items[$];
  out_item_t expected_status[$];
  int        errors = 0;
  int        items_taken = 0;
  bit        no_idle = 0;

  function automatic logic [23:0] q_of(logic [15:0] v);
    return {v, 8'd0};
  endfunction

  function automatic logic [39:0] ramp_step(logic [23:0] rate);
    logic [39:0] divisor;
    divisor = (m_speed == 0) ? 40'd1 : {16'd0, m_speed};
    return ({16'd0, rate} << (2 * FRAC)) / divisor;
  endfunction

  function automatic void ramp_up(logic [23:0] rate);
    logic [39:0] d;
    d = ramp_step(rate);
    m_speed = (d > {16'd0, SPEED_Q_MAX - m_speed}) ? SPEED_Q_MAX : m_speed + d[23:0];
  endfunction

  function automatic void ramp_down(logic [23:0] rate);
    logic [39:0] d;
    d = ramp_step(rate);
    m_speed = (d > {16'd0, m_speed}) ? 24'd0 : m_speed - d[23:0];
  endfunction

  // speed ramp, pulse start and position count at a step event
  function automatic void on_step(logic laser_low, logic limits_clear);
    logic [39:0] iv;
    case (m_mode)
      MODE_START: begin
        ramp_up(m_accel_start);
        if (m_speed > q_of(m_speed_mid)) m_mode = MODE_RUN;
      end
      MODE_RUN: ramp_up(m_accel_run);
      MODE_DECEL: begin
        ramp_down(m_decel_default);
        if (m_speed < q_of(m_speed_min)) begin
          m_speed = q_of(m_speed_min);
          m_mode = MODE_START;
          m_count_neg = laser_low;
          m_dir = !laser_low;
        end
      end
      MODE_HOME: begin
        ramp_up(m_accel_start);
        if (m_speed > q_of(m_speed_home)) m_speed = q_of(m_speed_home);
      end
      MODE_APPROACH: begin
        ramp_up(m_accel_start);
        if (m_speed > q_of(m_speed_approach)) m_speed = q_of(m_speed_approach);
      end
      MODE_HALT: begin
        ramp_down(m_decel_default);
        if (m_speed < q_of(m_speed_min)) begin
          m_speed = q_of(m_speed_min);
          m_mode = MODE_STOP;
        end
      end
      default: ;
    endcase
    if (m_speed < q_of(m_speed_min)) m_mode = MODE_STOP;
    if (m_speed > q_of(m_speed_max)) m_speed = q_of(m_speed_max);
    if (m_mode != MODE_STOP) begin
      if (limits_clear) begin
        iv = ({20'd0, 20'(US_PER_S)} << FRAC) / ((m_speed == 0) ? 40'd1 : {16'd0, m_speed});
        m_pulse = 1'b1;
        if (m_count_neg) begin
          if (m_pos_actual != 32'sh80000000) m_pos_actual = m_pos_actual - 1;
        end else begin
          if (m_pos_actual != 32'sh7FFFFFFF) m_pos_actual = m_pos_actual + 1;
        end
        m_interval = (iv > 40'hFFFFF) ? CNT20_MAX : iv[19:0];
        m_since_high = 8'd0;
        m_pulse_pending = 1'b1;
      end else begin
        m_mode = MODE_DECEL;
      end
    end else begin
      m_speed = q_of(m_speed_min);
    end
  endfunction

  // note: decel rate state shares m_decel_default, loaded by laser edges and register writes
  function automatic out_item_t predict_status(in_item_t it);
    out_item_t r;
    logic [39:0] rate;
    if (it.operation == OP_SET_MODE) begin
      if (it.mode_value != MODE_KEEP) m_mode = it.mode_value;
      m_dir = it.dir_pin_value;
      if (it.clear_position) begin
        m_pos_actual = 0;
        m_pos_measured = 0;
      end
    end else begin
      if (it.laser_edge && it.running) begin
        if (it.laser_low) m_pos_measured = m_pos_actual;
        rate = ({16'd0, m_speed} * 40'd200) / (40'd3 << FRAC);
        m_decel_default = (rate > 40'hFFFFFF) ? 24'hFFFFFF : rate[23:0];
        m_mode = MODE_DECEL;
      end
      if (m_since_step != CNT20_MAX) m_since_step = m_since_step + 20'd1;
      if (m_since_high != CNT8_MAX) m_since_high = m_since_high + 8'd1;
      if (m_since_step >= m_interval) begin
        m_since_step = '0;
        on_step(it.laser_low, it.limits_clear);
      end else if (m_pulse_pending && m_since_high >= PULSE_US) begin
        m_pulse_pending = 1'b0;
        m_pulse = 1'b0;
      end
    end
    r.pulse_level = m_pulse;
    r.dir_level = m_dir;
    r.mode_now = m_mode;
    r.speed_now = m_speed[23:8];
    r.position_actual = m_pos_actual;
    r.position_measured = m_pos_measured;
    return r;
  endfunction

  function automatic in_item_t tick_item(logic laser_low, logic edge_seen, logic lim,
                                         logic run);
    in_item_t it;
    it = '0;
    it.operation = OP_TICK;
    it.mode_value = 3'($urandom_range(7));
    it.dir_pin_value = 1'($urandom_range(1));
    it.clear_position = 1'($urandom_range(1));
    it.laser_low = laser_low;
    it.laser_edge = edge_seen;
    it.limits_clear = lim;
    it.running = run;
    return it;
  endfunction

  function automatic in_item_t mode_item(logic [2:0] m, logic dir_v, logic clr);
    in_item_t it;
    it = '0;
    it.operation = OP_SET_MODE;
    it.mode_value = m;
    it.dir_pin_value = dir_v;
    it.clear_position = clr;
    it.laser_low = 1'($urandom_range(1));
    it.laser_edge = 1'($urandom_range(1));
    it.limits_clear = 1'($urandom_range(1));
    it.running = 1'($urandom_range(1));
    return it;
  endfunction

  // mostly plain ticks, with mode writes, laser edges and limit faults sprinkled in
  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 7)
      return mode_item(3'($urandom_range(7)), 1'($urandom_range(1)),
                       $urandom_range(9) == 0);
    return tick_item(1'($urandom_range(1)), $urandom_range(24) == 0,
                     $urandom_range(19) != 0, $urandom_range(3) != 0);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: drives item_in from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      item_in.valid <= 1'b0;
      item_in.data <= '0;
    end else if (!item_in.valid || item_in.ready) begin
      if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
        item_in.valid <= 1'b1;
        item_in.data <= pending_items.pop_front();
      end else begin
        item_in.valid <= 1'b0;
      end
    end
  end

  // prediction at each accepted input item
  always @(posedge clk) begin
    if (!rst && item_in.valid && item_in.ready) begin
      expected_status.push_back(predict_status(item_in.data));
      items_taken <= items_taken + 1;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  int  hold_left = 0;
  bit  held_once = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_out.ready <= 1'b0;
    end else begin
      if (!held_once && items_taken >= 60) begin
        held_once = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        item_out.ready <= 1'b0;
      end else begin
        item_out.ready <= no_idle || $urandom_range(99) >= 36;
      end
    end
  end

  // result check against the oldest expected status
  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst && item_out.valid && item_out.ready) begin
      got = item_out.data;
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_status.pop_front();
        if (got.pulse_level !== want.pulse_level) begin
          errors++;
          $display("%0t: pulse_level expected %0b actual %0b", $time, want.pulse_level,
                   got.pulse_level);
        end
        if (got.dir_level !== want.dir_level) begin
          errors++;
          $display("%0t: dir_level expected %0b actual %0b", $time, want.dir_level,
                   got.dir_level);
        end
        if (got.mode_now !== want.mode_now) begin
          errors++;
          $display("%0t: mode_now expected %0d actual %0d", $time, want.mode_now,
                   got.mode_now);
        end
        if (got.speed_now !== want.speed_now) begin
          errors++;
          $display("%0t: speed_now expected %0d actual %0d", $time, want.speed_now,
                   got.speed_now);
        end
        if (got.position_actual !== want.position_actual) begin
          errors++;
          $display("%0t: position_actual expected %0d actual %0d", $time,
                   want.position_actual, got.position_actual);
        end
        if (got.position_measured !== want.position_measured) begin
          errors++;
          $display("%0t: position_measured expected %0d actual %0d", $time,
                   want.position_measured, got.position_measured);
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (item_out.valid && item_out.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("stepper_ramp_pulse_generator_test: done, errors");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || item_in.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ACCEL_START:   m_accel_start = val;
      REG_ACCEL_RUN:     m_accel_run = val;
      REG_DECEL_DEFAULT: m_decel_default = val;
      REG_SPEED_MIN:     m_speed_min = val[15:0];
      REG_SPEED_MID:     m_speed_mid = val[15:0];
      REG_SPEED_MAX:     m_speed_max = val[15:0];
      REG_SPEED_HOME:    m_speed_home = val[15:0];
      default:           m_speed_approach = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] a_s, logic [23:0] a_r, logic [23:0] d_d,
                           logic [15:0] s_min, logic [15:0] s_mid, logic [15:0] s_max,
                           logic [15:0] s_home, logic [15:0] s_appr);
    write_reg(REG_ACCEL_START, a_s);
    write_reg(REG_ACCEL_RUN, a_r);
    write_reg(REG_DECEL_DEFAULT, d_d);
    write_reg(REG_SPEED_MIN, {8'd0, s_min});
    write_reg(REG_SPEED_MID, {8'd0, s_mid});
    write_reg(REG_SPEED_MAX, {8'd0, s_max});
    write_reg(REG_SPEED_HOME, {8'd0, s_home});
    write_reg(REG_SPEED_APPROACH, {8'd0, s_appr});
  endtask

  // stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_accel_start = ACCEL_START_RST;
    m_accel_run = ACCEL_RUN_RST;
    m_decel_default = DECEL_DEFAULT_RST;
    m_speed_min = SPEED_MIN_RST;
    m_speed_mid = SPEED_MID_RST;
    m_speed_max = SPEED_MAX_RST;
    m_speed_home = SPEED_HOME_RST;
    m_speed_approach = SPEED_APPROACH_RST;
    m_speed = q_of(SPEED_MIN_RST);
    m_mode = MODE_STOP;
    m_count_neg = 1'b0;
    m_dir = 1'b0;
    m_pos_actual = 0;
    m_pos_measured = 0;
    m_interval = '0;
    m_since_step = '0;
    m_since_high = '0;
    m_pulse_pending = 1'b0;
    m_pulse = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, keep mode, every mode, laser edges, limit fault
    pending_items.push_back(tick_item(1'b0, 1'b0, 1'b1, 1'b0));
    pending_items.push_back(mode_item(MODE_KEEP, 1'b1, 1'b0));
    pending_items.push_back(mode_item(MODE_START, 1'b0, 1'b1));
    for (int i = 0; i < 3; i++) pending_items.push_back(tick_item(1'b0, 1'b0, 1'b1, 1'b1));
    pending_items.push_back(tick_item(1'b1, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(tick_item(1'b0, 1'b1, 1'b1, 1'b0));
    pending_items.push_back(tick_item(1'b0, 1'b1, 1'b1, 1'b1));
    pending_items.push_back(tick_item(1'b0, 1'b0, 1'b0, 1'b1));
    pending_items.push_back(mode_item(MODE_RUN, 1'b1, 1'b0));
    pending_items.push_back(mode_item(MODE_HOME, 1'b0, 1'b0));
    pending_items.push_back(mode_item(MODE_APPROACH, 1'b1, 1'b0));
    pending_items.push_back(mode_item(MODE_HALT, 1'b0, 1'b0));
    pending_items.push_back(mode_item(MODE_DECEL, 1'b1, 1'b0));
    pending_items.push_back(mode_item(MODE_STOP, 1'b0, 1'b1));
    pending_items.push_back(tick_item(1'b1, 1'b0, 1'b0, 1'b0));
    drain();

    // random phases across register settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(24'd1000, 24'd64000, 24'd64000, 16'd80, 16'd400, 16'd8000,
                     16'd2500, 16'd80);
        1: write_all(24'd500000, 24'hFFFFFF, 24'h100000, 16'd20000, 16'd30000,
                     16'd65535, 16'd40000, 16'd25000);
        2: write_all(24'd0, 24'd0, 24'd0, 16'd30000, 16'd30001, 16'd60000,
                     16'd35000, 16'd30000);
        3: write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        4: write_all(24'hFFFFFF, 24'd1, 24'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        default: write_all(24'd300000, 24'd900000, 24'd2000000, 16'd40000, 16'd20000,
                           16'd30000, 16'd50000, 16'd45000);
      endcase
      no_idle = (ph == 2);
      pending_items.push_back(mode_item(MODE_START, 1'($urandom_range(1)), 1'b1));
      for (int i = 0; i < 75; i++) pending_items.push_back(random_item());
      drain();
    end
    no_idle = 0;

    if (errors == 0 && expected_status.size() == 0) begin
      $display("stepper_ramp_pulse_generator_test: done, clean");
    end else begin
      if (expected_status.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_status.size());
      $display("stepper_ramp_pulse_generator_test: done, errors");
    end
    $finish;
  end

endmodule
